FILE: rtl/core/ps2_mouse_packet_tracker_defines.svh
// Assertion helpers for the mouse packet tracker
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked outside reset
`define PS2MT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define PS2MT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PS2MT_ASSERT(lbl, prop, msg)
`define PS2MT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/core/ps2mt_pkg.sv
package ps2mt_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 12;
  localparam int SIZE_W = 13;
  localparam int IDX_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  // Byte position within a packet
  localparam logic [IDX_W-1:0] IDX_FIRST  = 2'd0;
  localparam logic [IDX_W-1:0] IDX_SECOND = 2'd1;
  localparam logic [IDX_W-1:0] IDX_THIRD  = 2'd2;

  localparam int OPEN_MARK_BIT = 3;
  localparam int BUTTON_BIT    = 0;

  localparam logic [SIZE_W-1:0] CURSOR_MARGIN = 13'd16;
  localparam logic [SIZE_W-1:0] MAX_LIMIT     = 13'd4080;
  localparam logic [SIZE_W-1:0] WIDTH_RESET   = 13'd320;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET  = 13'd200;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             button_left;
  } result_t;

  // Cursor limit for a screen size: size - 16, held within 0..4080
  function automatic logic [POS_W-1:0] limit_of(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] diff;
    diff = size - CURSOR_MARGIN;
    if (size < CURSOR_MARGIN) begin
      return '0;
    end else if (diff > MAX_LIMIT) begin
      return MAX_LIMIT[POS_W-1:0];
    end else begin
      return diff[POS_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/ps2mt_in_reg.sv
module ps2mt_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ps2mt_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
  input  logic                          slot_free,
  output logic                          fire,
  output logic [ps2mt_pkg::BYTE_W-1:0]  data_byte
);

  logic held;

  // held byte moves on when the result side has room
  assign fire     = held && slot_free;
  assign s_tready = !held || slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_byte <= s_tdata;
    end
  end

endmodule

FILE: rtl/core/ps2mt_tracker.sv
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [ps2mt_pkg::BYTE_W-1:0]  data_byte,
  input  logic [ps2mt_pkg::POS_W-1:0]   limit_x,
  input  logic [ps2mt_pkg::POS_W-1:0]   limit_y,
  output logic                          done,
  output ps2mt_pkg::result_t            res
);

  logic [ps2mt_pkg::IDX_W-1:0]  byte_index;
  logic [ps2mt_pkg::IDX_W-1:0]  byte_index_next;
  logic [ps2mt_pkg::BYTE_W-1:0] packet_bytes [2];
  logic [ps2mt_pkg::POS_W-1:0]  cursor_x;
  logic [ps2mt_pkg::POS_W-1:0]  cursor_y;
  logic                         store_first;
  logic                         store_second;
  logic signed [ps2mt_pkg::POS_W+1:0] nx;
  logic signed [ps2mt_pkg::POS_W+1:0] ny;

  // Clamp a signed sum into 0..lim
  function automatic logic [ps2mt_pkg::POS_W-1:0] clamp_pos(
    input logic signed [ps2mt_pkg::POS_W+1:0] v,
    input logic [ps2mt_pkg::POS_W-1:0]        lim
  );
    if (v < 0) begin
      return '0;
    end else if (v[ps2mt_pkg::POS_W:0] > {1'b0, lim}) begin
      return lim;
    end else begin
      return v[ps2mt_pkg::POS_W-1:0];
    end
  endfunction

  // Deltas: x adds, y subtracts
  assign nx = $signed({2'b00, cursor_x}) + $signed({{6{packet_bytes[1][7]}}, packet_bytes[1]});
  assign ny = $signed({2'b00, cursor_y}) - $signed({{6{data_byte[7]}}, data_byte});

  assign res.pos_x       = clamp_pos(nx, limit_x);
  assign res.pos_y       = clamp_pos(ny, limit_y);
  assign res.button_left = packet_bytes[0][ps2mt_pkg::BUTTON_BIT];

  // Byte counter
  always_comb begin
    byte_index_next = byte_index;
    store_first     = 1'b0;
    store_second    = 1'b0;
    done            = 1'b0;
    if (fire) begin
      case (byte_index)
        ps2mt_pkg::IDX_SECOND: begin
          store_second    = 1'b1;
          byte_index_next = ps2mt_pkg::IDX_THIRD;
        end
        ps2mt_pkg::IDX_THIRD: begin
          done            = 1'b1;
          byte_index_next = ps2mt_pkg::IDX_FIRST;
        end
        default: begin
          // packet opener must carry the sync bit
          if (data_byte[ps2mt_pkg::OPEN_MARK_BIT]) begin
            store_first     = 1'b1;
            byte_index_next = ps2mt_pkg::IDX_SECOND;
          end else begin
            byte_index_next = ps2mt_pkg::IDX_FIRST;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= ps2mt_pkg::IDX_FIRST;
      cursor_x   <= '0;
      cursor_y   <= '0;
    end else begin
      byte_index <= byte_index_next;
      if (done) begin
        cursor_x <= res.pos_x;
        cursor_y <= res.pos_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_first) begin
      packet_bytes[0] <= data_byte;
    end
    if (store_second) begin
      packet_bytes[1] <= data_byte;
    end
  end

  `PS2MT_ASSERT(a_drop_opener,
    fire && byte_index == ps2mt_pkg::IDX_FIRST && !data_byte[ps2mt_pkg::OPEN_MARK_BIT]
      |=> byte_index == ps2mt_pkg::IDX_FIRST && $stable(cursor_x) && $stable(cursor_y),
    "misaligned opener changed tracker state")
  `PS2MT_ASSERT(a_done_third,
    done |-> byte_index == ps2mt_pkg::IDX_THIRD && fire,
    "result raised outside third byte")
  `PS2MT_ASSERT(a_cursor_limit,
    done |=> cursor_x <= $past(limit_x) && cursor_y <= $past(limit_y),
    "cursor exceeds limit after packet")
  `PS2MT_ASSERT(a_hold_idle,
    !fire |=> $stable(byte_index) && $stable(cursor_x) && $stable(cursor_y),
    "tracker state moved without an item")

endmodule

FILE: rtl/core/ps2mt_out_reg.sv
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_out_reg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  ps2mt_pkg::result_t                 res,
  output logic                               slot_free,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [2*ps2mt_pkg::POS_W-1:0]      m_tdata,   // [11:0] pos_x, [23:12] pos_y
  output logic                               m_tuser    // [0] button_left
);

  assign slot_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {res.pos_y, res.pos_x};
      m_tuser <= res.button_left;
    end
  end

  `PS2MT_ASSERT(a_no_overwrite,
    load |-> slot_free,
    "result loaded over an item not yet taken")

endmodule

FILE: rtl/core/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker. Bytes from the mouse enter on the s_ side, one item
// per byte; an opener byte without bit 3 set is dropped. Each completed
// three-byte packet moves the cursor (x plus the second byte, y minus the
// third, both signed) and clamps it to 0..screen size minus 16, at most 4080,
// then emits one item with the new position and the left button. One byte is
// taken every cycle as long as the result side keeps up; a byte is registered
// in the input register and its result in the output register that drives m_.
// Screen sizes are written on the cfg port (index 0 width, index 1 height,
// other indexes ignored); the user must write them only while no packet is in
// flight, as the block does not enforce this. They reset to 320 by 200.
module ps2_mouse_packet_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ps2mt_pkg::BYTE_W-1:0]        s_tdata,    // [7:0] data_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [2*ps2mt_pkg::POS_W-1:0]       m_tdata,    // [11:0] pos_x, [23:12] pos_y
  output logic                                m_tuser,    // [0] button_left
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ps2mt_pkg::SIZE_W-1:0]        cfg_data
);

  logic                          fire;
  logic                          slot_free;
  logic                          done;
  logic [ps2mt_pkg::BYTE_W-1:0]  data_byte;
  logic [ps2mt_pkg::POS_W-1:0]   limit_x;
  logic [ps2mt_pkg::POS_W-1:0]   limit_y;
  ps2mt_pkg::result_t            res;

  assign cfg_ready = 1'b1;

  // Limits are kept ready-made instead of the raw sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_x <= ps2mt_pkg::limit_of(ps2mt_pkg::WIDTH_RESET);
      limit_y <= ps2mt_pkg::limit_of(ps2mt_pkg::HEIGHT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ps2mt_pkg::CFG_SCREEN_WIDTH:  limit_x <= ps2mt_pkg::limit_of(cfg_data);
        ps2mt_pkg::CFG_SCREEN_HEIGHT: limit_y <= ps2mt_pkg::limit_of(cfg_data);
        default: ;
      endcase
    end
  end

  ps2mt_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .slot_free (slot_free),
    .fire      (fire),
    .data_byte (data_byte)
  );

  ps2mt_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (data_byte),
    .limit_x   (limit_x),
    .limit_y   (limit_y),
    .done      (done),
    .res       (res)
  );

  ps2mt_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (done),
    .res       (res),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

FILE: sim/tb_ps2_mouse_packet_tracker.sv
module tb_ps2_mouse_packet_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mt_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_PAD    = 8;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_PRINTED  = 50;

  // register indexes past the two sizes; writes there are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum {STEER_MIXED, STEER_UP, STEER_DOWN} steer_t;

  // Cursor predictor and store of expected moves
  class mouse_cursor_sb;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [IDX_W-1:0]  byte_idx;
    logic [BYTE_W-1:0] pkt [2];
    logic [POS_W-1:0]  cur_x;
    logic [POS_W-1:0]  cur_y;
    result_t           expected_moves [$];
    int                errors;
    int                n_bytes;
    int                n_dropped;
    int                n_moves;

    function new();
      width     = WIDTH_RESET;
      height    = HEIGHT_RESET;
      byte_idx  = IDX_FIRST;
      cur_x     = '0;
      cur_y     = '0;
      errors    = 0;
      n_bytes   = 0;
      n_dropped = 0;
      n_moves   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      case (idx)
        CFG_SCREEN_WIDTH: width = val;
        CFG_SCREEN_HEIGHT: height = val;
        default: ;
      endcase
    endfunction

    // size minus margin, held to 0..4080
    function int limit_for(logic [SIZE_W-1:0] size);
      int lim;
      lim = int'(size) - int'(CURSOR_MARGIN);
      if (lim < 0) lim = 0;
      if (lim > int'(MAX_LIMIT)) lim = int'(MAX_LIMIT);
      return lim;
    endfunction

    function logic [POS_W-1:0] clamp(int v, int lim);
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      return v[POS_W-1:0];
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      int      nx;
      int      ny;
      result_t r;
      n_bytes++;
      if (byte_idx > IDX_THIRD) byte_idx = IDX_FIRST;
      // opener without the mark bit is dropped
      if (byte_idx == IDX_FIRST && !b[OPEN_MARK_BIT]) begin
        n_dropped++;
        return;
      end
      if (byte_idx == IDX_FIRST || byte_idx == IDX_SECOND) begin
        pkt[byte_idx[0]] = b;
        byte_idx = byte_idx + 1'b1;
        return;
      end
      // third byte completes the packet
      byte_idx = IDX_FIRST;
      nx = int'(cur_x) + int'($signed(pkt[1]));
      ny = int'(cur_y) - int'($signed(b));
      cur_x = clamp(nx, limit_for(width));
      cur_y = clamp(ny, limit_for(height));
      r.pos_x       = cur_x;
      r.pos_y       = cur_y;
      r.button_left = pkt[0][BUTTON_BIT];
      expected_moves.push_back(r);
    endfunction

    task flag(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(logic [2*POS_W-1:0] data, logic user);
      result_t want;
      if (expected_moves.size() == 0) begin
        flag($sformatf("item with none expected: x=%0d y=%0d btn=%0b",
                       data[POS_W-1:0], data[2*POS_W-1:POS_W], user));
        return;
      end
      want = expected_moves.pop_front();
      n_moves++;
      if (data[POS_W-1:0] !== want.pos_x)
        flag($sformatf("pos_x got %0d want %0d", data[POS_W-1:0], want.pos_x));
      if (data[2*POS_W-1:POS_W] !== want.pos_y)
        flag($sformatf("pos_y got %0d want %0d", data[2*POS_W-1:POS_W], want.pos_y));
      if (user !== want.button_left)
        flag($sformatf("button_left got %0b want %0b", user, want.button_left));
    endtask

    function bit mid_packet();
      return byte_idx != IDX_FIRST;
    endfunction

    function int pending();
      return expected_moves.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [2*POS_W-1:0]     m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SIZE_W-1:0]      cfg_data;

  mouse_cursor_sb sb;
  bit             tx_idle;
  bit             rx_idle;
  bit             hold_req;
  int             cycles = 0;

  ps2_mouse_packet_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Cycle limit and result checking
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_ps2_mouse_packet_tracker: done, errors");
      $finish;
    end else if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one byte; called at a falling edge, returns at a falling edge.
  // tvalid stays high on return, so the caller either sends again or lowers it.
  task send_byte(input logic [BYTE_W-1:0] b);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every move, then let dropped bytes still in flight drain
  task settle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  function logic [BYTE_W-1:0] edge_delta();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'h81;
      default: return 8'hFF;
    endcase
  endfunction

  // y is subtracted, so growing y needs a negative byte
  function logic [BYTE_W-1:0] pick_delta(steer_t mode, bit is_y);
    bit grow;
    if (mode == STEER_MIXED) begin
      if ($urandom_range(0, 3) == 0) return edge_delta();
      return BYTE_W'($urandom_range(0, 255));
    end
    grow = (mode == STEER_UP);
    if (grow ^ is_y) return BYTE_W'($urandom_range(8'h60, 8'h7F));
    return BYTE_W'($urandom_range(8'h80, 8'hA0));
  endfunction

  function logic [SIZE_W-1:0] random_size();
    if ($urandom_range(0, 3) == 0) return SIZE_W'($urandom_range(0, 8191));
    return SIZE_W'($urandom_range(16, 4096));
  endfunction

  // Mostly whole packets, some stray and loose bytes; ends on a packet boundary
  task run_phase(input int n_items, input steer_t mode);
    int                sent;
    int                pick;
    bit                at_start;
    logic [BYTE_W-1:0] opener;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      opener = BYTE_W'($urandom_range(0, 255));
      if (pick < 7) begin
        opener[OPEN_MARK_BIT] = 1'b1;
        send_byte(opener);
        send_byte(pick_delta(mode, 1'b0));
        send_byte(pick_delta(mode, 1'b1));
        sent += 3;
      end else if (pick < 9) begin
        at_start = !sb.mid_packet();
        opener[OPEN_MARK_BIT] = 1'b0;
        send_byte(opener);
        if (!at_start) sent++;
      end else begin
        send_byte(opener);
        sent++;
      end
    end
    while (sb.mid_packet()) send_byte(BYTE_W'($urandom_range(0, 255)));
    s_tvalid <= 1'b0;
  endtask

  initial begin
    sb        = new();
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SCREEN_WIDTH;
    cfg_data  = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    hold_req  = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset sizes 320x200: dropped openers, zero move, delta extremes,
    // clamping at both ends, button set and clear
    send_byte(8'h00);
    send_byte(8'hF7);
    send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h09); send_byte(8'h7F); send_byte(8'h80);
    send_byte(8'hFF); send_byte(8'h7F); send_byte(8'h81);
    send_byte(8'h08); send_byte(8'h80); send_byte(8'h7F);
    send_byte(8'h0A); send_byte(8'h80); send_byte(8'h7F);
    send_byte(8'h08); send_byte(8'hFF); send_byte(8'h01);
    s_tvalid <= 1'b0;
    settle();

    // screen smaller than the margin: cursor pinned at zero
    set_reg(CFG_SCREEN_WIDTH, 13'd0);
    set_reg(CFG_SCREEN_HEIGHT, 13'd15);
    run_phase(20, STEER_MIXED);
    settle();

    set_reg(CFG_SCREEN_WIDTH, 13'd16);
    set_reg(CFG_SCREEN_HEIGHT, 13'd17);
    run_phase(20, STEER_UP);
    settle();

    // oversized screen: drive the cursor up to the 4080 ceiling
    set_reg(CFG_SCREEN_WIDTH, 13'd8191);
    set_reg(CFG_SCREEN_HEIGHT, 13'd4097);
    run_phase(120, STEER_UP);
    settle();

    // shrink under a far-out cursor; result side held off while bytes keep coming
    set_reg(CFG_SCREEN_WIDTH, 13'd100);
    set_reg(CFG_SCREEN_HEIGHT, 13'd60);
    set_reg(CFG_SPARE_2, 13'd8191);
    tx_idle  = 1'b0;
    hold_req = 1'b1;
    run_phase(40, STEER_MIXED);
    settle();
    tx_idle = 1'b1;

    set_reg(CFG_SCREEN_WIDTH, 13'd4096);
    set_reg(CFG_SCREEN_HEIGHT, 13'd4096);
    set_reg(CFG_SPARE_3, random_size());
    run_phase(40, STEER_DOWN);
    settle();

    repeat (3) begin
      set_reg(CFG_SCREEN_WIDTH, random_size());
      set_reg(CFG_SCREEN_HEIGHT, random_size());
      run_phase(20, STEER_MIXED);
      settle();
    end

    // closing stretch at full rate on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_reg(CFG_SCREEN_WIDTH, WIDTH_RESET);
    set_reg(CFG_SCREEN_HEIGHT, HEIGHT_RESET);
    run_phase(60, STEER_MIXED);
    settle();

    $display("run covered %0d bytes (%0d dropped openers), %0d cursor moves checked,",
             sb.n_bytes, sb.n_dropped, sb.n_moves);
    $display("screen sizes from zero to 8191 incl. unused register writes; %0d errors",
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb_ps2_mouse_packet_tracker: done, clean");
    end else begin
      $display("tb_ps2_mouse_packet_tracker: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ps2mt_pkg.sv
rtl/core/ps2mt_in_reg.sv
rtl/core/ps2mt_tracker.sv
rtl/core/ps2mt_out_reg.sv
rtl/core/ps2_mouse_packet_tracker.sv
sim/tb_ps2_mouse_packet_tracker.sv
